// ===== rtl/nc3s_pkg.sv =====
// Shared types, constants and helper functions of the normalised 3x3 smoother.
// Used by the top level and the testbench; depends on nothing else.
package nc3s_pkg;

    localparam int DEF_MAX_SIDE   = 512;
    localparam int DEF_PIXEL_BITS = 8;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int IMG_W      = 10;
    localparam int KROW_W     = 24;
    localparam int COEF_W     = 8;
    localparam int KSUM_W     = 12;
    localparam int OUT_W      = 28;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int KDIM       = 3;

    localparam logic [IMG_W-1:0]  IMG_RESET  = IMG_W'(512);
    localparam logic [KROW_W-1:0] KROW_RESET = 24'h010101;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE   = 2'd0,
        REG_KERNEL_TOP   = 2'd1,
        REG_KERNEL_MID   = 2'd2,
        REG_KERNEL_BOTTOM = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic signed [COEF_W-1:0] coef_of(input logic [KROW_W-1:0] row,
                                                         input logic [1:0] col);
        logic signed [COEF_W-1:0] c;
        case (col)
            2'd0:    c = row[7:0];
            2'd1:    c = row[15:8];
            2'd2:    c = row[23:16];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/normalized_conv3x3_smoother_unit.sv =====
// Top level of the normalised 3x3 smoother: stream ports, line store, tap sequencer and divider.
// Depends on nc3s_pkg and nc3s_ram.
// A square image arrives in raster order, one pixel per item, and each result is the 3x3
// weighted sum of a pixel's neighbourhood (outside pixels count as zero), scaled by
// 2^FRAC_BITS and divided by the kernel sum, truncated toward zero and saturated to 28 bits.
// The result for pixel p follows input pixel p+N+1; after the image, N+1 flush items
// (tuser high) drain the remaining results. An item that gives a result is followed by nine
// reads through the single read port of the line store, then, unless the kernel sum is zero,
// a restoring divider that produces one quotient bit per cycle, and any wait for the previous
// result to be taken; no new item is accepted until then. Writing the image size abandons
// the current image.
module normalized_conv3x3_smoother_unit #(
    parameter int MAX_SIDE   = nc3s_pkg::DEF_MAX_SIDE,
    parameter int PIXEL_BITS = nc3s_pkg::DEF_PIXEL_BITS,
    parameter int FRAC_BITS  = nc3s_pkg::DEF_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pixel
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,
    // func
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // smoothed
    output logic [nc3s_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    // zero_kernel_sum
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nc3s_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nc3s_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import nc3s_pkg::*;

    localparam int HIST   = 2 * MAX_SIDE + 4;
    localparam int ADDR_W = $clog2(HIST);
    localparam int AS_W   = ADDR_W + 2;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int COL_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CNT_W  = $clog2(MAX_SIDE * MAX_SIDE + 1) + 1;
    localparam int ACC_W  = COEF_W + PIXEL_BITS + 5;
    localparam int DVD_W  = ACC_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DVD_W + 1);
    localparam int CMP_W  = ((DVD_W > OUT_W) ? DVD_W : OUT_W) + 1;

    state_t state_reg, state_next;

    logic [IMG_W-1:0]  img_reg;
    logic [KROW_W-1:0] krow_reg [KDIM];
    logic [CNT_W-1:0]  in_cnt_reg, in_cnt_next;
    logic [ADDR_W-1:0] in_ptr_reg, in_ptr_next;
    logic [ADDR_W-1:0] out_ptr_reg, out_ptr_next;
    logic [SIDE_W-1:0] row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [1:0]        tap_r_reg, tap_r_next, tap_c_reg, tap_c_next;
    logic [1:0]        rd_r_reg, rd_c_reg;
    logic              rd_valid_reg, rd_hit_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic              last_reg, last_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    logic [KSUM_W-1:0] dsr_reg, dsr_next;
    logic [KSUM_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              m_valid_reg;
    logic signed [OUT_W-1:0] m_data_reg;
    logic              m_last_reg, m_zero_reg;

    logic [SIDE_W-1:0] side;
    logic [CNT_W-1:0]  total;
    logic signed [KSUM_W-1:0] ksum;
    logic              s_fire, cfg_fire, out_load;
    logic              ram_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PIXEL_BITS-1:0] ram_rdata;
    logic signed [AS_W-1:0] addr_s;
    logic              hit;
    logic signed [OUT_W-1:0] result;

    always_comb begin
        int img_i;
        int n_i;
        img_i = int'(img_reg);
        if (img_i < 1) begin
            n_i = 1;
        end else if (img_i > MAX_SIDE) begin
            n_i = MAX_SIDE;
        end else begin
            n_i = img_i;
        end
        side  = SIDE_W'(n_i);
        total = CNT_W'(n_i * n_i);
    end

    always_comb begin
        logic signed [KSUM_W-1:0] s;
        s = '0;
        for (int r = 0; r < KDIM; r++) begin
            for (int c = 0; c < KDIM; c++) begin
                s = s + KSUM_W'(coef_of(krow_reg[r], 2'(c)));
            end
        end
        ksum = s;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        logic signed [AS_W-1:0] roff;
        logic signed [AS_W-1:0] coff;
        logic row_ok;
        logic col_ok;
        case (tap_r_reg)
            2'd0:    roff = -$signed(AS_W'(side));
            2'd2:    roff = $signed(AS_W'(side));
            default: roff = '0;
        endcase
        coff   = $signed(AS_W'(tap_c_reg)) - AS_W'(1);
        addr_s = $signed(AS_W'(out_ptr_reg)) + roff + coff;
        if (addr_s < 0) begin
            addr_s = addr_s + AS_W'(HIST);
        end else if (addr_s >= $signed(AS_W'(HIST))) begin
            addr_s = addr_s - AS_W'(HIST);
        end
        case (tap_r_reg)
            2'd0:    row_ok = (row_reg != '0);
            2'd2:    row_ok = ((SIDE_W+1)'(row_reg) + 1'b1 < (SIDE_W+1)'(side));
            default: row_ok = 1'b1;
        endcase
        case (tap_c_reg)
            2'd0:    col_ok = (col_reg != '0);
            2'd2:    col_ok = ((SIDE_W+1)'(col_reg) + 1'b1 < (SIDE_W+1)'(side));
            default: col_ok = 1'b1;
        endcase
        hit       = row_ok && col_ok;
        ram_raddr = addr_s[ADDR_W-1:0];
    end

    assign ram_we  = s_fire && !s_tuser && (in_cnt_reg < total || row_reg >= side);
    assign wr_addr = (in_cnt_reg >= total) ? '0 : in_ptr_reg;

    nc3s_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (HIST)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (s_tdata[PIXEL_BITS-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic pending;
        logic [CNT_W-1:0] cnt_inc;
        state_next = state_reg;
        pending    = (in_cnt_reg >= total) && ((SIDE_W)'(row_reg) < side);
        cnt_inc    = in_cnt_reg + 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser) begin
                        if (pending) begin
                            state_next = ST_READ;
                        end
                    end else if (in_cnt_reg >= total) begin
                        if (row_reg >= side && CNT_W'(1) >= CNT_W'(side) + CNT_W'(2)) begin
                            state_next = ST_READ;
                        end
                    end else if (cnt_inc >= CNT_W'(side) + CNT_W'(2) && row_reg < side) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (tap_r_reg == 2'd2 && tap_c_reg == 2'd2) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:  state_next = ST_SETUP;
            ST_SETUP: state_next = (ksum == '0) ? ST_DONE : ST_DIV;
            ST_DIV: begin
                if (dcnt_reg == DCNT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        logic [CNT_W-1:0] cnt_base;
        logic [ADDR_W-1:0] ptr_base;
        logic [KSUM_W-1:0] shifted;
        logic signed [ACC_W-1:0] prod;
        logic [ACC_W-1:0] mag;
        in_cnt_next  = in_cnt_reg;
        in_ptr_next  = in_ptr_reg;
        out_ptr_next = out_ptr_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        tap_r_next   = tap_r_reg;
        tap_c_next   = tap_c_reg;
        acc_next     = acc_reg;
        last_next    = last_reg;
        neg_next     = neg_reg;
        zero_next    = zero_reg;
        dsr_next     = dsr_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        cnt_base     = in_cnt_reg;
        ptr_base     = in_ptr_reg;
        prod = $signed(ACC_W'(coef_of(krow_reg[rd_r_reg], rd_c_reg)))
             * $signed(ACC_W'({1'b0, ram_rdata}));
        shifted = {rem_reg[KSUM_W-2:0], quo_reg[DVD_W-1]};
        mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);

        if (rd_valid_reg && rd_hit_reg) begin
            acc_next = acc_reg + prod;
        end

        case (state_reg)
            ST_IDLE: begin
                tap_r_next = '0;
                tap_c_next = '0;
                acc_next   = '0;
                last_next  = ((SIDE_W+1)'(col_reg) + 1'b1 >= (SIDE_W+1)'(side))
                          && ((SIDE_W+1)'(row_reg) + 1'b1 >= (SIDE_W+1)'(side));
                if (s_fire && !s_tuser) begin
                    if (in_cnt_reg >= total) begin
                        if (row_reg >= side) begin
                            cnt_base     = '0;
                            ptr_base     = '0;
                            out_ptr_next = '0;
                            row_next     = '0;
                            col_next     = '0;
                            last_next    = (side == SIDE_W'(1));
                        end
                    end
                    if (in_cnt_reg < total || row_reg >= side) begin
                        in_cnt_next = cnt_base + 1'b1;
                        in_ptr_next = (ptr_base == ADDR_W'(HIST - 1)) ? '0 : ptr_base + 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (tap_c_reg == 2'd2) begin
                    tap_c_next = '0;
                    tap_r_next = tap_r_reg + 1'b1;
                end else begin
                    tap_c_next = tap_c_reg + 1'b1;
                end
            end
            ST_SETUP: begin
                zero_next = (ksum == '0);
                neg_next  = acc_reg[ACC_W-1] ^ ksum[KSUM_W-1];
                dsr_next  = ksum[KSUM_W-1] ? KSUM_W'(-ksum) : KSUM_W'(ksum);
                rem_next  = '0;
                quo_next  = DVD_W'(mag) << FRAC_BITS;
                dcnt_next = DCNT_W'(DVD_W);
                out_ptr_next = (out_ptr_reg == ADDR_W'(HIST - 1)) ? '0 : out_ptr_reg + 1'b1;
                if ((SIDE_W+1)'(col_reg) + 1'b1 >= (SIDE_W+1)'(side)) begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_DIV: begin
                dcnt_next = dcnt_reg - 1'b1;
                if (shifted >= dsr_reg) begin
                    rem_next = shifted - dsr_reg;
                    quo_next = {quo_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_next = shifted;
                    quo_next = {quo_reg[DVD_W-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase

        if (cfg_fire && cfg_index == REG_IMAGE_SIZE) begin
            in_cnt_next  = '0;
            in_ptr_next  = '0;
            out_ptr_next = '0;
            row_next     = '0;
            col_next     = '0;
        end
    end

    always_comb begin
        logic [CMP_W-1:0] q;
        q = CMP_W'(quo_reg);
        if (zero_reg) begin
            result = '0;
        end else if (neg_reg) begin
            if (q > CMP_W'(134217728)) begin
                result = {1'b1, {(OUT_W-1){1'b0}}};
            end else begin
                result = OUT_W'(-$signed(q));
            end
        end else if (q > CMP_W'(134217727)) begin
            result = {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            result = OUT_W'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            img_reg      <= IMG_RESET;
            krow_reg[0]  <= KROW_RESET;
            krow_reg[1]  <= KROW_RESET;
            krow_reg[2]  <= KROW_RESET;
            in_cnt_reg   <= '0;
            in_ptr_reg   <= '0;
            out_ptr_reg  <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_cnt_reg   <= in_cnt_next;
            in_ptr_reg   <= in_ptr_next;
            out_ptr_reg  <= out_ptr_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            rd_valid_reg <= (state_reg == ST_READ);
            if (cfg_fire) begin
                case (cfg_index)
                    REG_IMAGE_SIZE:    img_reg     <= cfg_data[IMG_W-1:0];
                    REG_KERNEL_TOP:    krow_reg[0] <= cfg_data;
                    REG_KERNEL_MID:    krow_reg[1] <= cfg_data;
                    REG_KERNEL_BOTTOM: krow_reg[2] <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tap_r_reg  <= tap_r_next;
        tap_c_reg  <= tap_c_next;
        rd_r_reg   <= tap_r_reg;
        rd_c_reg   <= tap_c_reg;
        rd_hit_reg <= hit;
        acc_reg    <= acc_next;
        last_reg   <= last_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        dsr_reg    <= dsr_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dcnt_reg   <= dcnt_next;
        if (out_load) begin
            m_data_reg <= result;
            m_last_reg <= last_reg;
            m_zero_reg <= zero_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(unsigned'(m_data_reg));
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_zero_reg;

endmodule

// ===== rtl/nc3s_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Used for the pixel line store; depends on nothing else.
module nc3s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1028
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for normalized_conv3x3_smoother_unit: pixels and flush items go in as
// a stream, and each result is checked against a predictor of the smoother kept in this file.
// Depends on nc3s_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
    import nc3s_pkg::*;

    localparam int SIDE_MAX   = 512;
    localparam int RING_DEPTH = 2 * SIDE_MAX + 4;
    localparam int CYCLE_CAP  = 2000000;
    localparam int SETTLE     = 60;

    typedef struct packed {
        logic signed [OUT_W-1:0] smoothed;
        logic                    last_of_image;
        logic                    zero_sum;
    } smooth_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    normalized_conv3x3_smoother_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor state.
    logic [IMG_W-1:0]  side_reg;
    logic [KROW_W-1:0] krow [KDIM];
    logic [7:0]        ring [RING_DEPTH];
    int unsigned       col_pos, row_pos, pix_count;

    smooth_res_t pending_q [$];
    int errors, items_sent, results_seen;
    int cycles;
    int burst_left;
    int ready_mode, ready_left;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(20, 300);
        end
        ready_left = ready_left - 1;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        smooth_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result data=%h last=%b flag=%b", $time, m_tdata,
                         m_tlast, m_tuser);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (m_tdata !== {{(OUT_DATA_W-OUT_W){1'b0}}, e.smoothed}) begin
                    $display("%0t: smoothed expected %h actual %h", $time, e.smoothed, m_tdata);
                    errors++;
                end
                if (m_tlast !== e.last_of_image) begin
                    $display("%0t: last expected %b actual %b", $time, e.last_of_image, m_tlast);
                    errors++;
                end
                if (m_tuser !== e.zero_sum) begin
                    $display("%0t: zero-sum flag expected %b actual %b", $time, e.zero_sum,
                             m_tuser);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned side_now();
        int unsigned n;
        n = side_reg;
        if (n < 1) n = 1;
        if (n > SIDE_MAX) n = SIDE_MAX;
        return n;
    endfunction

    function automatic smooth_res_t smooth_pixel(int unsigned n);
        smooth_res_t res;
        longint acc, ksum, v, rr, cc;
        logic signed [COEF_W-1:0] co;
        logic [7:0] px;
        acc = 0;
        ksum = 0;
        for (int r = 0; r < KDIM; r++) begin
            for (int c = 0; c < KDIM; c++) begin
                rr = longint'(row_pos) + r - 1;
                cc = longint'(col_pos) + c - 1;
                px = 8'd0;
                if (rr >= 0 && rr < n && cc >= 0 && cc < n)
                    px = ring[(rr * n + cc) % RING_DEPTH];
                co = krow[r][8*c +: 8];
                acc += longint'(co) * longint'(px);
                ksum += longint'(co);
            end
        end
        if (ksum == 0) begin
            v = 0;
            res.zero_sum = 1'b1;
        end else begin
            v = (acc * 256) / ksum;
            if (v > 134217727) v = 134217727;
            if (v < -134217728) v = -134217728;
            res.zero_sum = 1'b0;
        end
        res.smoothed = v[OUT_W-1:0];
        col_pos++;
        if (col_pos >= n) begin
            col_pos = 0;
            row_pos++;
        end
        res.last_of_image = (row_pos >= n);
        return res;
    endfunction

    function automatic void predict_item(logic flush, logic [7:0] px);
        int unsigned n, total;
        n = side_now();
        total = n * n;
        if (!flush) begin
            if (pix_count >= total) begin
                if (row_pos < n) return;
                pix_count = 0;
                row_pos = 0;
                col_pos = 0;
            end
            ring[pix_count % RING_DEPTH] = px;
            pix_count++;
            if (pix_count >= n + 2 && row_pos < n) pending_q.push_back(smooth_pixel(n));
        end else if (pix_count >= total && row_pos < n) begin
            pending_q.push_back(smooth_pixel(n));
        end
    endfunction

    task automatic send_item(logic flush, logic [7:0] px);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= flush;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        predict_item(flush, px);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_SIZE) begin
            side_reg = value[IMG_W-1:0];
            col_pos = 0;
            row_pos = 0;
            pix_count = 0;
        end else begin
            krow[int'(idx) - 1] = value;
        end
    endtask

    task automatic send_image(int unsigned n);
        for (int i = 0; i < n * n; i++) send_item(1'b0, 8'($urandom));
        for (int i = 0; i <= n; i++) send_item(1'b1, 8'($urandom));
    endtask

    task automatic test_default_size();
        // Default size and kernel, a partial image, then the largest size register value.
        for (int i = 0; i < 520; i++) send_item(1'b0, 8'($urandom));
        cfg_write(REG_IMAGE_SIZE, 24'h3FF);
        for (int i = 0; i < 10; i++) send_item(1'b0, 8'($urandom));
    endtask

    task automatic test_small_cases();
        cfg_write(REG_IMAGE_SIZE, 24'hFFFC00);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b1, 8'h00);
        cfg_write(REG_IMAGE_SIZE, 24'd2);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h5A);
        send_item(1'b0, 8'hA5);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'h00);
        send_item(1'b0, 8'h01);
        send_item(1'b0, 8'h80);
    endtask

    task automatic test_kernel_extremes();
        cfg_write(REG_IMAGE_SIZE, 24'd3);
        cfg_write(REG_KERNEL_TOP, 24'h000000);
        cfg_write(REG_KERNEL_MID, 24'h000000);
        cfg_write(REG_KERNEL_BOTTOM, 24'h000000);
        send_image(3);
        cfg_write(REG_KERNEL_TOP, 24'h7F7F7F);
        cfg_write(REG_KERNEL_MID, 24'h7F7F7F);
        cfg_write(REG_KERNEL_BOTTOM, 24'h7F7F7F);
        send_image(3);
        cfg_write(REG_KERNEL_TOP, 24'h808080);
        cfg_write(REG_KERNEL_MID, 24'h808080);
        cfg_write(REG_KERNEL_BOTTOM, 24'h808080);
        send_image(3);
        cfg_write(REG_KERNEL_TOP, 24'h7F807F);
        cfg_write(REG_KERNEL_MID, 24'h01FF01);
        cfg_write(REG_KERNEL_BOTTOM, 24'h808101);
        send_image(3);
    endtask

    task automatic test_random_images();
        int unsigned n;
        int cut;
        while (items_sent < 1850) begin
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(REG_KERNEL_TOP, 24'($urandom));
                cfg_write(REG_KERNEL_MID, 24'($urandom));
                cfg_write(REG_KERNEL_BOTTOM, 24'($urandom));
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            cfg_write(REG_IMAGE_SIZE, {14'($urandom), 10'(n)});
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(0, n * n);
                for (int i = 0; i < cut; i++) send_item(1'b0, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 2)) begin
                    for (int i = 0; i < n * n; i++) begin
                        if ($urandom_range(0, 29) == 0) send_item(1'b1, 8'($urandom));
                        send_item(1'b0, 8'($urandom));
                    end
                    for (int i = 0; i <= n; i++) begin
                        if ($urandom_range(0, 19) == 0) send_item(1'b0, 8'($urandom));
                        send_item(1'b1, 8'($urandom));
                    end
                    if ($urandom_range(0, 4) == 0) send_item(1'b1, 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_IMAGE_SIZE;
        cfg_data  <= '0;
        cycles = 0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        burst_left = 0;
        ready_left = 0;
        ready_mode = 0;
        side_reg = IMG_RESET;
        for (int r = 0; r < KDIM; r++) krow[r] = KROW_RESET;
        col_pos = 0;
        row_pos = 0;
        pix_count = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_size();
        test_small_cases();
        test_kernel_extremes();
        test_random_images();
        drain();

        $display("Sent %0d items (pixels and flushes) over many image sizes and kernels,",
                 items_sent);
        $display("and checked %0d smoothed results.", results_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nc3s_pkg.sv
rtl/nc3s_ram.sv
rtl/normalized_conv3x3_smoother_unit.sv
test/tb_top.sv
